// ===== hw/rtl/mbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared constants and types for the modular binomial coefficient block.
// ----------------------------------------------------------------------------
package mbc_pkg;

    localparam int unsigned VAL_W = 30;
    localparam logic [29:0] MODULUS = 30'd998244353;
    // Fermat exponent p-2 used to invert the top factorial.
    localparam logic [29:0] INV_EXP = 30'd998244351;
    // Barrett reciprocal floor(2^60 / p); it fits in 31 bits.
    localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'd998244353);
    // Pipeline depth of the modular multiplier.
    localparam int MM_LAT = 6;

    typedef enum logic [3:0] {
        ST_FAC_SEED,
        ST_FAC_MUL,
        ST_FAC_WAIT,
        ST_POW_ACC,
        ST_POW_ACC_WAIT,
        ST_POW_SQR,
        ST_POW_SQR_WAIT,
        ST_INV_SEED,
        ST_INV_MUL,
        ST_INV_WAIT,
        ST_RUN
    } seq_state_t;

endpackage

// ===== hw/rtl/mbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mbc_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_modmul
// Pipelined multiply modulo p with Barrett reduction and a tag side channel.
// ----------------------------------------------------------------------------
module mbc_modmul #(
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [29:0]      in_a,
    input  logic [29:0]      in_b,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [29:0]      out_res,
    output logic [TAG_W-1:0] out_tag
);

    logic [mbc_pkg::MM_LAT-1:0] vld_reg;
    logic [TAG_W-1:0]           tag_reg [mbc_pkg::MM_LAT];
    logic [59:0]                x_reg;
    logic [61:0]                t_reg;
    logic [31:0]                xlo2_reg;
    logic [31:0]                xlo3_reg;
    logic [31:0]                qp_reg;
    logic [31:0]                r_reg;
    logic [31:0]                r1_reg;
    logic [29:0]                r2_reg;

    logic [59:0] prod;
    logic [61:0] t_next;
    logic [30:0] q_est;
    logic [60:0] qp_full;
    logic [31:0] r1_next;
    logic [31:0] r2_next;
    logic [31:0] p_ext;

    assign p_ext   = {2'b00, mbc_pkg::MODULUS};
    assign prod    = {30'd0, in_a} * {30'd0, in_b};
    assign t_next  = {31'd0, x_reg[59:29]} * {31'd0, mbc_pkg::BARRETT_M};
    assign q_est   = t_reg[61:31];
    assign qp_full = {30'd0, q_est} * {31'd0, mbc_pkg::MODULUS};
    // The estimate is at most two short, so the remainder stays below 3p.
    assign r1_next = (r_reg >= p_ext) ? (r_reg - p_ext) : r_reg;
    assign r2_next = (r1_reg >= p_ext) ? (r1_reg - p_ext) : r1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[mbc_pkg::MM_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int i = 1; i < mbc_pkg::MM_LAT; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        x_reg    <= prod;
        t_reg    <= t_next;
        xlo2_reg <= x_reg[31:0];
        xlo3_reg <= xlo2_reg;
        qp_reg   <= qp_full[31:0];
        r_reg    <= xlo3_reg - qp_reg;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next[29:0];
    end

    assign out_valid = vld_reg[mbc_pkg::MM_LAT-1];
    assign out_tag   = tag_reg[mbc_pkg::MM_LAT-1];
    assign out_res   = r2_reg;

endmodule

// ===== hw/rtl/modular_binomial_coefficient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_binomial_coefficient
// Binomial coefficient n choose k modulo 998244353 from factorial tables.
// ----------------------------------------------------------------------------
// Usage:
// Queries arrive on the s_ stream; each transaction carries n (top_count)
// and k (choose_count, signed). Each query yields exactly one transaction
// on the m_ stream with n choose k mod 998244353, or zero when k is
// negative, k exceeds n, or n exceeds MAX_TOP.
// After reset the block builds its tables and holds s_tready low meanwhile:
// an upward sweep writes i! mod p, a square-and-multiply run raises the top
// factorial to p-2, and a downward sweep writes the inverse factorials.
// Each table step waits on the six-stage modular multiplier.
// Once running, one query is taken per cycle while s_tready is high. A result
// reaches m_tdata by this path: the tables (three RAMs, the inverse table
// duplicated for its two reads) are read at the accepting edge, then come
// two chained six-stage multipliers and the write into the output queue.
// Results collect in a 16-entry output queue; the block counts queries in
// flight plus queued results and drops s_tready only when 16 are
// outstanding, so a stalled receiver never loses a result.
// ----------------------------------------------------------------------------
module modular_binomial_coefficient #(
    parameter int MAX_TOP = 16383
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [13:0] top_count, [28:14] choose_count, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] binomial_value, rest zero
);

    localparam int DEPTH = MAX_TOP + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] TOP_IDX = AW'(MAX_TOP);
    localparam int QD    = 16;
    localparam int QW    = $clog2(QD);

    // Start-up sequencer state.
    mbc_pkg::seq_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [29:0]   acc_reg, acc_next;
    logic [29:0]   base_reg, base_next;
    logic [29:0]   exp_reg, exp_next;

    logic          seq_valid;
    logic [29:0]   seq_a;
    logic [29:0]   seq_b;
    logic          wr_fac;
    logic          wr_inv;
    logic [AW-1:0] wr_addr;
    logic [29:0]   wr_data;
    logic          running;

    // Shared multiplier (start-up steps, then the first query product).
    logic          mm1_in_valid;
    logic [29:0]   mm1_a;
    logic [29:0]   mm1_b;
    logic [30:0]   mm1_tag_in;
    logic          mm1_vld;
    logic [29:0]   mm1_res;
    logic [30:0]   mm1_tag;
    logic          mm2_vld;
    logic [29:0]   mm2_res;
    logic          mm2_tag;

    // Query front end.
    logic          s_acc;
    logic [13:0]   q_n;
    logic          q_kneg;
    logic [13:0]   q_k;
    logic [13:0]   q_diff;
    logic          q_ok;
    logic          q_vld_reg;
    logic          q_ok_reg;
    logic [29:0]   fac_rd;
    logic [29:0]   inva_rd;
    logic [29:0]   invb_rd;

    // Output queue.
    logic [29:0]   oq_mem [QD];
    logic [QW-1:0] oq_wr_reg;
    logic [QW-1:0] oq_rd_reg;
    logic [QW:0]   oq_cnt_reg;
    logic [QW:0]   pend_reg;
    logic          oq_push;
    logic          oq_pop;
    logic [29:0]   oq_wdata;

    assign running = (state_reg == mbc_pkg::ST_RUN);

    // Next state of the start-up sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbc_pkg::ST_FAC_SEED:     state_next = mbc_pkg::ST_FAC_MUL;
            mbc_pkg::ST_FAC_MUL:      state_next = mbc_pkg::ST_FAC_WAIT;
            mbc_pkg::ST_FAC_WAIT:
            begin
                if (mm1_vld)
                begin
                    state_next = (idx_reg == TOP_IDX) ? mbc_pkg::ST_POW_ACC
                                                      : mbc_pkg::ST_FAC_MUL;
                end
            end
            mbc_pkg::ST_POW_ACC:      state_next = mbc_pkg::ST_POW_ACC_WAIT;
            mbc_pkg::ST_POW_ACC_WAIT:
            begin
                if (mm1_vld)
                begin
                    state_next = mbc_pkg::ST_POW_SQR;
                end
            end
            mbc_pkg::ST_POW_SQR:      state_next = mbc_pkg::ST_POW_SQR_WAIT;
            mbc_pkg::ST_POW_SQR_WAIT:
            begin
                if (mm1_vld)
                begin
                    state_next = (exp_reg[29:1] == 29'd0) ? mbc_pkg::ST_INV_SEED
                                                          : mbc_pkg::ST_POW_ACC;
                end
            end
            mbc_pkg::ST_INV_SEED:     state_next = mbc_pkg::ST_INV_MUL;
            mbc_pkg::ST_INV_MUL:      state_next = mbc_pkg::ST_INV_WAIT;
            mbc_pkg::ST_INV_WAIT:
            begin
                if (mm1_vld)
                begin
                    state_next = (idx_reg == AW'(1)) ? mbc_pkg::ST_RUN
                                                     : mbc_pkg::ST_INV_MUL;
                end
            end
            mbc_pkg::ST_RUN:          state_next = mbc_pkg::ST_RUN;
            default:                  state_next = mbc_pkg::ST_FAC_SEED;
        endcase
    end

    // Sequencer outputs: multiplier operands, table writes, working registers.
    always_comb
    begin
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        exp_next  = exp_reg;
        seq_valid = 1'b0;
        seq_a     = acc_reg;
        seq_b     = 30'(idx_reg);
        wr_fac    = 1'b0;
        wr_inv    = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = mm1_res;
        case (state_reg)
            mbc_pkg::ST_FAC_SEED:
            begin
                wr_fac   = 1'b1;
                wr_addr  = '0;
                wr_data  = 30'd1;
                acc_next = 30'd1;
                idx_next = AW'(1);
            end
            mbc_pkg::ST_FAC_MUL:
            begin
                seq_valid = 1'b1;
            end
            mbc_pkg::ST_FAC_WAIT:
            begin
                if (mm1_vld)
                begin
                    wr_fac    = 1'b1;
                    acc_next  = mm1_res;
                    base_next = mm1_res;
                    idx_next  = idx_reg + AW'(1);
                    if (idx_reg == TOP_IDX)
                    begin
                        acc_next = 30'd1;
                        exp_next = mbc_pkg::INV_EXP;
                    end
                end
            end
            mbc_pkg::ST_POW_ACC:
            begin
                seq_valid = 1'b1;
                seq_b     = base_reg;
            end
            mbc_pkg::ST_POW_ACC_WAIT:
            begin
                if (mm1_vld && exp_reg[0])
                begin
                    acc_next = mm1_res;
                end
            end
            mbc_pkg::ST_POW_SQR:
            begin
                seq_valid = 1'b1;
                seq_a     = base_reg;
                seq_b     = base_reg;
            end
            mbc_pkg::ST_POW_SQR_WAIT:
            begin
                if (mm1_vld)
                begin
                    base_next = mm1_res;
                    exp_next  = exp_reg >> 1;
                end
            end
            mbc_pkg::ST_INV_SEED:
            begin
                wr_inv   = 1'b1;
                wr_addr  = TOP_IDX;
                wr_data  = acc_reg;
                idx_next = TOP_IDX;
            end
            mbc_pkg::ST_INV_MUL:
            begin
                seq_valid = 1'b1;
            end
            mbc_pkg::ST_INV_WAIT:
            begin
                if (mm1_vld)
                begin
                    wr_inv   = 1'b1;
                    wr_addr  = idx_reg - AW'(1);
                    acc_next = mm1_res;
                    idx_next = idx_reg - AW'(1);
                end
            end
            mbc_pkg::ST_RUN:
            begin
                seq_valid = 1'b0;
            end
            default:
            begin
                seq_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbc_pkg::ST_FAC_SEED;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
    end

    // Query decode. k is valid only when non-negative, not above n, and n
    // lies inside the table.
    assign s_tready = running && (pend_reg != (QW+1)'(QD));
    assign s_acc    = s_tvalid && s_tready;
    assign q_n      = s_tdata[13:0];
    assign q_kneg   = s_tdata[28];
    assign q_k      = s_tdata[27:14];
    assign q_diff   = q_n - q_k;
    assign q_ok     = !q_kneg && (q_k <= q_n) && ({18'd0, q_n} <= 32'(MAX_TOP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else
        begin
            q_vld_reg <= s_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        q_ok_reg <= q_ok;
    end

    mbc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_fac_ram (
        .clk   (clk),
        .we    (wr_fac),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (AW'(q_n)),
        .rdata (fac_rd)
    );

    mbc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_inva_ram (
        .clk   (clk),
        .we    (wr_inv),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (AW'(q_k)),
        .rdata (inva_rd)
    );

    mbc_ram #(.WIDTH(30), .DEPTH(DEPTH)) u_invb_ram (
        .clk   (clk),
        .we    (wr_inv),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (AW'(q_diff)),
        .rdata (invb_rd)
    );

    // First product: fac[n] * invfac[k]; invfac[n-k] and the range flag
    // ride along as the tag to meet it at the second multiplier.
    assign mm1_in_valid = running ? q_vld_reg : seq_valid;
    assign mm1_a        = running ? fac_rd : seq_a;
    assign mm1_b        = running ? inva_rd : seq_b;
    assign mm1_tag_in   = {q_ok_reg, invb_rd};

    mbc_modmul #(.TAG_W(31)) u_mul_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm1_in_valid),
        .in_a      (mm1_a),
        .in_b      (mm1_b),
        .in_tag    (mm1_tag_in),
        .out_valid (mm1_vld),
        .out_res   (mm1_res),
        .out_tag   (mm1_tag)
    );

    mbc_modmul #(.TAG_W(1)) u_mul_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mm1_vld && running),
        .in_a      (mm1_res),
        .in_b      (mm1_tag[29:0]),
        .in_tag    (mm1_tag[30]),
        .out_valid (mm2_vld),
        .out_res   (mm2_res),
        .out_tag   (mm2_tag)
    );

    // Output queue. pend_reg counts queries accepted but not yet delivered,
    // which bounds the queue occupancy and keeps it from overflowing.
    assign oq_push  = mm2_vld;
    assign oq_wdata = mm2_tag ? mm2_res : 30'd0;
    assign m_tvalid = (oq_cnt_reg != '0);
    assign oq_pop   = m_tvalid && m_tready;
    assign m_tdata  = {2'b00, oq_mem[oq_rd_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + QW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + QW'(1);
            end
            oq_cnt_reg <= oq_cnt_reg + (QW+1)'(oq_push) - (QW+1)'(oq_pop);
            pend_reg   <= pend_reg + (QW+1)'(s_acc) - (QW+1)'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= oq_wdata;
        end
    end

endmodule

// ===== hw/rtl/mbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_checker
// Port-level checks for the modular binomial coefficient block.
// ----------------------------------------------------------------------------
module mbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every result is a residue below the modulus, padding bits zero.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:30] == 2'b00) &&
                     (m_tdata[29:0] < mbc_pkg::MODULUS))
        else $error("result out of range");

    // Right after reset the tables are being built: no query is taken.
    a_init_ready: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("query accepted before tables are filled");

    // No result can appear right after reset.
    a_init_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind modular_binomial_coefficient mbc_checker u_mbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_modular_binomial_coefficient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_binomial_coefficient
// Self-checking bench for the modular binomial coefficient block.
// ----------------------------------------------------------------------------
// The bench builds its own factorial and inverse-factorial tables modulo the
// prime, then sends a short table of directed queries followed by random
// ones. Every result transaction is checked against a queue of predicted
// coefficients. Both stream sides idle at random, and the receiver holds off
// once for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_modular_binomial_coefficient;

    localparam int TOP_LIMIT = 16383;
    localparam int RANDOM_QUERIES = 1630;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [63:0] PRIME = 64'd998244353;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [13:0] top_count, [28:14] choose_count, rest zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [29:0] binomial_value, rest zero

    // Directed row: n, k, and an optional typed-in expectation.
    typedef struct {
        logic [13:0] top;
        logic [14:0] choose;
        bit          typed;
        logic [29:0] value;
    } query_row_t;

    logic [29:0] fact_mod [0:TOP_LIMIT];
    logic [29:0] inv_fact_mod [0:TOP_LIMIT];
    logic [29:0] pending_values [$];
    query_row_t  directed_rows [$];

    int  failures = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  queries_sent = 0;
    bit  quiet_phase = 0;
    bit  hold_off_done = 0;
    bit  hold_off_go = 0;

    modular_binomial_coefficient #(.MAX_TOP(TOP_LIMIT)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [29:0] times_mod(logic [63:0] a, logic [63:0] b);
        return 30'((a * b) % PRIME);
    endfunction

    function automatic logic [29:0] power_mod(logic [29:0] base, logic [29:0] expo);
        logic [29:0] acc;
        logic [29:0] sq;
        logic [29:0] e;
        acc = 30'd1;
        sq = base;
        e = expo;
        while (e != 0)
        begin
            if (e[0])
                acc = times_mod(acc, sq);
            sq = times_mod(sq, sq);
            e = e >> 1;
        end
        return acc;
    endfunction

    task automatic build_tables();
        fact_mod[0] = 30'd1;
        for (int i = 1; i <= TOP_LIMIT; i++)
            fact_mod[i] = times_mod(fact_mod[i-1], i);
        inv_fact_mod[TOP_LIMIT] = power_mod(fact_mod[TOP_LIMIT], 30'(PRIME - 2));
        for (int i = TOP_LIMIT; i > 0; i--)
            inv_fact_mod[i-1] = times_mod(inv_fact_mod[i], i);
    endtask

    // Coefficient n choose k mod p; zero for negative k or k above n.
    function automatic logic [29:0] binomial_mod(logic [13:0] n, logic [14:0] k);
        int kk;
        kk = $signed(k);
        if (kk < 0 || kk > int'(n))
            return 30'd0;
        return times_mod(times_mod(fact_mod[n], inv_fact_mod[kk]), inv_fact_mod[n - kk]);
    endfunction

    task automatic add_row(int n, int k, bit typed, logic [29:0] v);
        query_row_t r;
        r.top = 14'(n);
        r.choose = 15'(k);
        r.typed = typed;
        r.value = v;
        directed_rows.push_back(r);
    endtask

    // Offer one query, record its expectation, and wait for acceptance.
    task automatic send_query(logic [13:0] n, logic [14:0] k, bit typed, logic [29:0] v);
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, k, n};
        pending_values.push_back(typed ? v : binomial_mod(n, k));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        queries_sent++;
        @(negedge clk);
    endtask

    // Receiver: random short stalls, one long hold-off, none near the end.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_go && !hold_off_done)
            begin
                m_tready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_off_done = 1;
            end
            if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result checker, sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_values.size() == 0)
            begin
                $error("unexpected result transaction, binomial_value actual %0d",
                       m_tdata[29:0]);
                failures++;
            end
            else
            begin
                logic [29:0] want;
                want = pending_values.pop_front();
                if (m_tdata[29:0] !== want)
                begin
                    $error("binomial_value expected %0d actual %0d", want, m_tdata[29:0]);
                    failures++;
                end
                if (m_tdata[31:30] !== 2'b00)
                begin
                    $error("padding expected 0 actual %0d", m_tdata[31:30]);
                    failures++;
                end
            end
        end
    end

    // Watchdog over the whole run, including the start-up table fill.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [13:0] n;
        logic [14:0] k;
        int sel;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        build_tables();
        // Extremes and the zero cases, typed where obvious.
        add_row(0, 0, 1, 30'd1);
        add_row(TOP_LIMIT, 0, 1, 30'd1);
        add_row(TOP_LIMIT, TOP_LIMIT, 1, 30'd1);
        add_row(TOP_LIMIT, 1, 1, 30'(TOP_LIMIT));
        add_row(TOP_LIMIT, TOP_LIMIT - 1, 1, 30'(TOP_LIMIT));
        add_row(5, -1, 1, 30'd0);
        add_row(5, -16384, 1, 30'd0);
        add_row(0, 1, 1, 30'd0);
        add_row(100, 101, 1, 30'd0);
        add_row(TOP_LIMIT, 16383, 1, 30'd1);
        add_row(0, 16383, 1, 30'd0);
        add_row(5, 2, 1, 30'd10);
        add_row(TOP_LIMIT, 8191, 0, 0);
        add_row(10922, 5461, 0, 0);
        add_row(12345, 678, 0, 0);
        add_row(1000, 500, 0, 0);
        add_row(TOP_LIMIT, -2, 1, 30'd0);
        add_row(8192, 4096, 0, 0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed_rows[i])
            send_query(directed_rows[i].top, directed_rows[i].choose,
                       directed_rows[i].typed, directed_rows[i].value);
        for (int i = 0; i < RANDOM_QUERIES; i++)
        begin
            if (i == 300)
                hold_off_go = 1;
            if (i >= RANDOM_QUERIES - 200)
                quiet_phase = 1;
            n = 14'($urandom);
            sel = $urandom_range(0, 9);
            if (sel < 7)
                k = 15'($urandom_range(0, n));
            else if (sel == 7)
                k = 15'($urandom);
            else if (sel == 8)
                k = 15'(int'(n) + $urandom_range(1, 16383 - n + 1));
            else
                k = {1'b1, 14'($urandom)};
            if (sel == 8 && n == TOP_LIMIT)
                k = 15'h7FFF;
            send_query(n, k, 0, 0);
        end
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("Sent %0d queries (directed extremes, zero cases, random n and k).",
                 queries_sent);
        $display("Checked %0d results under random stalls and one long hold-off.",
                 results_seen);
        if (failures == 0 && pending_values.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
